// ----- src/ofr_pkg.sv -----
// ofr_pkg: shared widths and register map of the orifice flow meter
// used by ofr_sqrt, ofr_mul, orifice_flow_rate and ofr_checker; depends on nothing

package ofr_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int OFFSET_W   = 12;
    localparam int GAIN_W     = 24;
    localparam int PRESS_W    = 32;
    localparam int ROOT_W     = 16;
    localparam int PROD_W     = GAIN_W + ROOT_W;
    localparam int FLOW_W     = 32;
    localparam int FRAC_SHIFT = 4;
    localparam int Q8_SHIFT   = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_ENABLE = 2'd0;
    localparam reg_idx_t REG_OFFSET = 2'd1;
    localparam reg_idx_t REG_GAIN   = 2'd2;

endpackage

// ----- src/ofr_div.sv -----
// ofr_div: restoring divider, one quotient bit per cycle
// depends on nothing; widths come from the instantiating module

module ofr_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] shift_reg, shift_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             ge;

    // shift in the next dividend bit, subtract when it fits
    assign rem_sh   = {rem_reg, shift_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(NUM_W - 1);
            shift_next = num;
            rem_next   = '0;
            den_next   = den;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[NUM_W-2:0], ge};
            rem_next   = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
    end

    assign done = done_reg;
    assign quo  = shift_reg;

endmodule

// ----- src/ofr_sqrt.sv -----
// ofr_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on ofr_pkg for the radicand and root widths

module ofr_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ofr_pkg::PRESS_W-1:0] radicand,
    output logic                         done,
    output logic [ofr_pkg::ROOT_W-1:0]  root
);

    localparam int RW    = ofr_pkg::ROOT_W;
    localparam int PW    = ofr_pkg::PRESS_W;
    localparam int CNT_W = $clog2(RW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]    rad_reg, rad_next;
    logic [RW:0]      rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [RW+2:0]    rem_sh;
    logic [RW+2:0]    trial;
    logic [RW+2:0]    rem_diff;
    logic             ge;

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh   = {rem_reg, rad_reg[PW-1:PW-2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;
    assign ge       = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RW - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[PW-3:0], 2'b00};
            rem_next  = ge ? rem_diff[RW:0] : rem_sh[RW:0];
            root_next = {root_reg[RW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- src/ofr_mul.sv -----
// ofr_mul: shift-add multiplier, one multiplier bit per cycle, lsb first
// depends on ofr_pkg for the gain, root and product widths

module ofr_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ofr_pkg::GAIN_W-1:0] gain,
    input  logic [ofr_pkg::ROOT_W-1:0] mplier,
    output logic                        done,
    output logic [ofr_pkg::PROD_W-1:0] product
);

    localparam int GW    = ofr_pkg::GAIN_W;
    localparam int RW    = ofr_pkg::ROOT_W;
    localparam int PW    = ofr_pkg::PROD_W;
    localparam int CNT_W = $clog2(RW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]    acc_reg, acc_next;
    logic [GW-1:0]    gain_reg, gain_next;
    logic [GW:0]      part_sum;

    // upper half accumulates, multiplier bits leave from the bottom
    assign part_sum = {1'b0, acc_reg[PW-1:RW]} + (acc_reg[0] ? {1'b0, gain_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        gain_next = gain_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RW - 1);
            acc_next  = {{GW{1'b0}}, mplier};
            gain_next = gain;
        end
        else if (busy_reg)
        begin
            acc_next = {part_sum, acc_reg[RW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        gain_reg <= gain_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- src/orifice_flow_rate.sv -----
// orifice_flow_rate: top level of the orifice-plate flow meter
// depends on ofr_pkg, ofr_div, ofr_sqrt and ofr_mul
//
//   channel   dir   handshake              payload
//   -------   ---   --------------------   -----------------------------
//   in        in    in_valid / in_stall    sample_mv[11:0]
//   out       out   out_valid / out_stall  flow_rate[31:0], flow_valid
//   cfg       in    apb psel/penable       enable, zero offset, gain
//
// an enabled sample goes from accept to the result beat through setup, the
// serial divider, the serial square root, the serial multiplier and the
// hand-off to the output register
// a sample taken while disabled skips the arithmetic and goes straight to
// the hand-off, reporting the held flow marked invalid
// one sample is in work at a time; the output register lets the next sample
// be taken while the last beat still waits on out_stall
// rst_n clears control state, the registers and the held flow at once

module orifice_flow_rate #(
    parameter int FULL_SCALE_MV   = 3300,
    parameter int MAX_PRESSURE_PA = 3920
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample beat
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ofr_pkg::SAMPLE_W-1:0]   sample_mv,
    // result beat
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ofr_pkg::FLOW_W-1:0]     flow_rate,
    output logic                           flow_valid,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ofr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ofr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ofr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int SW      = ofr_pkg::SAMPLE_W;
    localparam int OW      = ofr_pkg::OFFSET_W;
    localparam int GW      = ofr_pkg::GAIN_W;
    localparam int PRW     = ofr_pkg::PRESS_W;
    localparam int RW      = ofr_pkg::ROOT_W;
    localparam int MW      = ofr_pkg::PROD_W;
    localparam int FW      = ofr_pkg::FLOW_W;
    localparam int FS      = ofr_pkg::FRAC_SHIFT;
    localparam int DW      = ofr_pkg::APB_DATA_W;
    // widths of the pressure mapping follow from the two parameters
    localparam int MAXP_W  = $clog2(MAX_PRESSURE_PA + 1);
    localparam int SPAN_W  = OW + MAXP_W;
    localparam int NUM_W   = SPAN_W + ofr_pkg::Q8_SHIFT;
    localparam int DEN_W   = $clog2(FULL_SCALE_MV + 1);
    localparam int QX_W    = (NUM_W > PRW) ? NUM_W : PRW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_SQRT,
        S_MUL,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic           out_valid_reg, out_valid_next;
    logic [FW-1:0]  flow_rate_reg, flow_rate_next;
    logic           flow_valid_reg, flow_valid_next;
    logic [FW-1:0]  last_flow_reg, last_flow_next;
    logic [FW-1:0]  res_flow_reg, res_flow_next;
    logic           res_valid_reg, res_valid_next;
    logic [SW-1:0]  sample_reg, sample_next;

    logic           enable_reg;
    logic [OW-1:0]  offset_reg;
    logic [GW-1:0]  gain_reg;

    logic           cfg_wr;
    ofr_pkg::reg_idx_t cfg_idx;

    logic           in_beat;
    logic           out_beat;

    logic           no_span;
    logic [SW-1:0]  diff;
    logic [SPAN_W-1:0] span;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic           div_start, div_done;
    logic [NUM_W-1:0]  div_quo;
    logic [QX_W-1:0]   quo_x;
    logic [PRW-1:0] pressure;
    logic           sqrt_start, sqrt_done;
    logic [RW-1:0]  root;
    logic           mul_start, mul_done;
    logic [MW-1:0]  product;
    logic [FW-1:0]  flow_sat;

    // ---------------- register port ----------------

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            offset_reg <= '0;
            gain_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                ofr_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                ofr_pkg::REG_OFFSET: offset_reg <= pwdata[OW-1:0];
                ofr_pkg::REG_GAIN:   gain_reg   <= pwdata[GW-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            ofr_pkg::REG_ENABLE: prdata = DW'(enable_reg);
            ofr_pkg::REG_OFFSET: prdata = DW'(offset_reg);
            ofr_pkg::REG_GAIN:   prdata = DW'(gain_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- pressure mapping ----------------

    // a sample at or below the offset, or an offset at or above full scale,
    // maps to zero pressure; a zero dividend over a unit divisor gives that
    assign no_span = ({1'b0, offset_reg} >= (OW + 1)'(FULL_SCALE_MV))
                   || (sample_reg <= offset_reg);
    assign diff    = sample_reg - offset_reg;
    assign span    = SPAN_W'(diff) * SPAN_W'(MAX_PRESSURE_PA);
    assign div_num = no_span ? '0 : {span, {ofr_pkg::Q8_SHIFT{1'b0}}};
    assign div_den = no_span ? DEN_W'(1) : DEN_W'(FULL_SCALE_MV) - DEN_W'(offset_reg);

    assign div_start = (state_reg == S_PREP);

    ofr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // pressure in q8 saturates at 32 bits when the quotient needs more bits
    assign quo_x    = QX_W'(div_quo);
    assign pressure = (|quo_x[QX_W-1:PRW]) ? '1 : quo_x[PRW-1:0];

    // ---------------- root and gain ----------------

    assign sqrt_start = (state_reg == S_DIV) && div_done;

    ofr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (pressure),
        .done     (sqrt_done),
        .root     (root)
    );

    assign mul_start = (state_reg == S_SQRT) && sqrt_done;

    ofr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .gain    (gain_reg),
        .mplier  (root),
        .done    (mul_done),
        .product (product)
    );

    // root is q4, gain q16: drop four bits to land in q16, then saturate
    assign flow_sat = (|product[MW-1:FW+FS]) ? '1 : product[FW+FS-1:FS];

    // ---------------- sequencer and output register ----------------

    assign in_stall  = (state_reg != S_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign out_beat  = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        flow_rate_next  = flow_rate_reg;
        flow_valid_next = flow_valid_reg;
        last_flow_next  = last_flow_reg;
        res_flow_next   = res_flow_reg;
        res_valid_next  = res_valid_reg;
        sample_next     = sample_reg;

        if (out_beat)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    sample_next = sample_mv;
                    if (enable_reg)
                    begin
                        state_next = S_PREP;
                    end
                    else
                    begin
                        // disabled: report the held flow, marked invalid
                        res_flow_next  = last_flow_reg;
                        res_valid_next = 1'b0;
                        state_next     = S_DONE;
                    end
                end
            end
            S_PREP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    res_flow_next  = flow_sat;
                    res_valid_next = 1'b1;
                    last_flow_next = flow_sat;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    flow_rate_next  = res_flow_reg;
                    flow_valid_next = res_valid_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            flow_rate_reg  <= '0;
            flow_valid_reg <= 1'b0;
            last_flow_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            flow_rate_reg  <= flow_rate_next;
            flow_valid_reg <= flow_valid_next;
            last_flow_reg  <= last_flow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_flow_reg  <= res_flow_next;
        res_valid_reg <= res_valid_next;
        sample_reg    <= sample_next;
    end

    assign out_valid  = out_valid_reg;
    assign flow_rate  = flow_rate_reg;
    assign flow_valid = flow_valid_reg;

endmodule

// ----- src/ofr_checker.sv -----
// ofr_checker: port-level checks on the orifice flow meter
// depends on ofr_pkg for widths; bound to orifice_flow_rate below

module ofr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [ofr_pkg::FLOW_W-1:0] flow_rate,
    input logic                       pready
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(flow_rate))
        else $error("flow_rate changed while stalled");

    // one sample at a time: the beat after an accepted sample is stalled
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while one is in work");

    // a new result only appears after the block was busy with a sample
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat without a sample in work");

    // the register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind orifice_flow_rate ofr_checker u_ofr_checker (.*);
